// ===== design/sha_pkg.sv =====
// Shared types, constants and functions of the SHA-256 hash engine.
`timescale 1ns / 1ps

package sha_pkg;

    // Initial hash values
    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Padding marker byte
    localparam logic [7:0] PAD_MARKER = 8'h80;

    // First byte position that holds the bit length
    localparam logic [5:0] LEN_POS = 6'd56;

    // Last byte position and last round of a block
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;

    // Controls for the message schedule window
    typedef struct packed {
        logic       load;
        logic       expand;
        logic [7:0] data_byte;
    } sha_sched_ctrl_t;

    // Controls for the round unit and hash state
    typedef struct packed {
        logic       init;
        logic       step;
        logic       accum;
        logic       restart;
        logic [5:0] round_idx;
    } sha_round_ctrl_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // Round constant lookup
    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        unique case (r)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
        endcase
        round_k = k;
    endfunction

endpackage

// ===== design/sha_sched.sv =====
// Block window: byte-wise fill of the 16-word block and rolling message schedule.
`timescale 1ns / 1ps

module sha_sched (
    input  logic                     clk,
    input  sha_pkg::sha_sched_ctrl_t ctrl,
    output logic [31:0]              sched_word
);

    logic [31:0] win_reg  [16];
    logic [31:0] win_next [16];
    logic [31:0] expand_word;

    // Next schedule word from the fixed taps t-2, t-7, t-15 and t-16
    assign expand_word = sha_pkg::small_sigma1(win_reg[14]) + win_reg[9]
                       + sha_pkg::small_sigma0(win_reg[1]) + win_reg[0];

    // Current round word sits at the head of the window
    assign sched_word = win_reg[0];

    // Shift in a byte, or advance the window by one word
    always_comb
    begin
        for (int j = 0; j < 16; j++)
        begin
            win_next[j] = win_reg[j];
        end
        if (ctrl.load)
        begin
            for (int j = 0; j < 15; j++)
            begin
                win_next[j] = {win_reg[j][23:0], win_reg[j + 1][31:24]};
            end
            win_next[15] = {win_reg[15][23:0], ctrl.data_byte};
        end
        else if (ctrl.expand)
        begin
            for (int j = 0; j < 15; j++)
            begin
                win_next[j] = win_reg[j + 1];
            end
            win_next[15] = expand_word;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 16; j++)
        begin
            win_reg[j] <= win_next[j];
        end
    end

endmodule

// ===== design/sha_round.sv =====
// Round unit: working variables, one compression round per cycle, and hash state.
`timescale 1ns / 1ps

module sha_round (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sha_pkg::sha_round_ctrl_t ctrl,
    input  logic [31:0]              sched_word,
    input  logic [2:0]               word_idx,
    output logic [31:0]              digest_word
);

    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] mj;

    // Round function
    assign ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1 = v_reg[7] + sha_pkg::big_sigma1(v_reg[4]) + ch
              + sha_pkg::round_k(ctrl.round_idx) + sched_word;
    assign t2 = sha_pkg::big_sigma0(v_reg[0]) + mj;

    assign digest_word = h_reg[word_idx];

    // Working variables: load from hash state, then advance one round
    always_ff @(posedge clk)
    begin
        if (ctrl.init)
        begin
            for (int j = 0; j < 8; j++)
            begin
                v_reg[j] <= h_reg[j];
            end
        end
        else if (ctrl.step)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    // Hash state: fold in the block result, or restart the message
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < 8; j++)
            begin
                h_reg[j] <= sha_pkg::H_INIT[j];
            end
        end
        else if (ctrl.restart)
        begin
            for (int j = 0; j < 8; j++)
            begin
                h_reg[j] <= sha_pkg::H_INIT[j];
            end
        end
        else if (ctrl.accum)
        begin
            for (int j = 0; j < 8; j++)
            begin
                h_reg[j] <= h_reg[j] + v_reg[j];
            end
        end
    end

endmodule

// ===== design/sha256_hash_engine.sv =====
// SHA-256 hash engine top level. Bytes are taken one per cycle while idle; each 64th byte
// starts a compression. End of message: one padding byte per cycle up to the block end,
// then a compression, twice when the length no longer fits, then eight output transfers,
// one per cycle when taken at once.
// Reset loads the initial hash values and clears the byte count and sequencer; the block
// window holds no reset value and is always fully written before a compression reads it.
`timescale 1ns / 1ps

module sha256_hash_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] message_byte
    input  logic        s_axis_tuser,   // [0] byte_present
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last_word
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_FINAL = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [2:0] LAST_WORD_IDX = 3'd7;

    logic [2:0]  state_reg,      state_next;
    logic [5:0]  round_cnt_reg,  round_cnt_next;
    logic [5:0]  fill_reg,       fill_next;
    logic [63:0] count_reg,      count_next;
    logic [63:0] len_reg,        len_next;
    logic        padding_reg,    padding_next;
    logic        pad_first_reg,  pad_first_next;
    logic        len_ok_reg,     len_ok_next;
    logic        last_block_reg, last_block_next;
    logic [2:0]  word_idx_reg,   word_idx_next;

    logic        s_fire;
    logic        m_fire;
    logic [63:0] count_inc;
    logic [31:0] sched_word;

    sha_pkg::sha_sched_ctrl_t sched_ctrl;
    sha_pkg::sha_round_ctrl_t round_ctrl;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tuser  = word_idx_reg;
    assign m_axis_tlast  = (word_idx_reg == LAST_WORD_IDX);

    assign s_fire    = s_axis_tvalid && s_axis_tready;
    assign m_fire    = m_axis_tvalid && m_axis_tready;
    assign count_inc = count_reg + {63'd0, s_axis_tuser};

    sha_sched u_sched (
        .clk        (clk),
        .ctrl       (sched_ctrl),
        .sched_word (sched_word)
    );

    sha_round u_round (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (round_ctrl),
        .sched_word  (sched_word),
        .word_idx    (word_idx_reg),
        .digest_word (m_axis_tdata)
    );

    // Block sequencer
    always_comb
    begin
        state_next       = state_reg;
        round_cnt_next   = round_cnt_reg;
        fill_next        = fill_reg;
        count_next       = count_reg;
        len_next         = len_reg;
        padding_next     = padding_reg;
        pad_first_next   = pad_first_reg;
        len_ok_next      = len_ok_reg;
        last_block_next  = last_block_reg;
        word_idx_next    = word_idx_reg;
        sched_ctrl       = '0;
        round_ctrl       = '0;
        round_ctrl.round_idx = round_cnt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    // Take the byte into the window
                    if (s_axis_tuser)
                    begin
                        sched_ctrl.load      = 1'b1;
                        sched_ctrl.data_byte = s_axis_tdata;
                        fill_next            = fill_reg + 6'd1;
                        count_next           = count_inc;
                    end
                    // Latch the bit length and arm padding
                    if (s_axis_tlast)
                    begin
                        padding_next   = 1'b1;
                        pad_first_next = 1'b1;
                        len_ok_next    = 1'b0;
                        len_next       = {count_inc[60:0], 3'b000};
                    end
                    if (s_axis_tuser && (fill_reg == sha_pkg::LAST_POS))
                    begin
                        state_next      = ST_ROUND;
                        round_cnt_next  = '0;
                        last_block_next = 1'b0;
                        round_ctrl.init = 1'b1;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                // Insert marker, zero or length byte at the current position
                sched_ctrl.load = 1'b1;
                fill_next       = fill_reg + 6'd1;
                pad_first_next  = 1'b0;
                if (pad_first_reg)
                begin
                    sched_ctrl.data_byte = sha_pkg::PAD_MARKER;
                    if (fill_reg < sha_pkg::LEN_POS)
                    begin
                        len_ok_next = 1'b1;
                    end
                end
                else if (len_ok_reg && (fill_reg >= sha_pkg::LEN_POS))
                begin
                    sched_ctrl.data_byte = len_reg[63:56];
                    len_next             = {len_reg[55:0], 8'd0};
                end
                else
                begin
                    sched_ctrl.data_byte = 8'd0;
                end
                if (fill_reg == sha_pkg::LAST_POS)
                begin
                    last_block_next = len_ok_reg;
                    len_ok_next     = 1'b1;
                    state_next      = ST_ROUND;
                    round_cnt_next  = '0;
                    round_ctrl.init = 1'b1;
                end
            end
            ST_ROUND:
            begin
                // One round per cycle over the rolling schedule
                round_ctrl.step   = 1'b1;
                sched_ctrl.expand = 1'b1;
                round_cnt_next    = round_cnt_reg + 6'd1;
                if (round_cnt_reg == sha_pkg::LAST_ROUND)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                // Fold the block into the hash state and pick the next step
                round_ctrl.accum = 1'b1;
                if (!padding_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (last_block_reg)
                begin
                    state_next    = ST_OUT;
                    word_idx_next = '0;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT:
            begin
                // Hand out digest words, then restart for the next message
                if (m_fire)
                begin
                    word_idx_next = word_idx_reg + 3'd1;
                    if (word_idx_reg == LAST_WORD_IDX)
                    begin
                        round_ctrl.restart = 1'b1;
                        count_next         = '0;
                        padding_next       = 1'b0;
                        state_next         = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            round_cnt_reg  <= '0;
            fill_reg       <= '0;
            count_reg      <= '0;
            padding_reg    <= 1'b0;
            pad_first_reg  <= 1'b0;
            len_ok_reg     <= 1'b0;
            last_block_reg <= 1'b0;
            word_idx_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            round_cnt_reg  <= round_cnt_next;
            fill_reg       <= fill_next;
            count_reg      <= count_next;
            padding_reg    <= padding_next;
            pad_first_reg  <= pad_first_next;
            len_ok_reg     <= len_ok_next;
            last_block_reg <= last_block_next;
            word_idx_reg   <= word_idx_next;
        end
    end

    // Length shift register carries payload only
    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

    // Input and output sides never open together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output both open");

    // A compression always starts on a full block
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_cnt_reg == 6'd0) |-> (fill_reg == 6'd0))
        else $error("compression started on a partial block");

    // The hash state is folded only after all rounds
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINAL) |-> ($past(state_reg) == ST_ROUND
                                     && $past(round_cnt_reg) == sha_pkg::LAST_ROUND))
        else $error("final add without a full round pass");

    // The final digest word returns the block to a clean idle state
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_fire && m_axis_tlast) |=> (s_axis_tready && count_reg == 64'd0 && !padding_reg))
        else $error("digest end did not restart the message");

    // Digest words are shown only after a final padded block
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> (padding_reg && last_block_reg && m_axis_tuser == 3'd0))
        else $error("digest shown without a finished message");

endmodule

// ===== tb/sha256_hash_engine_test.sv =====
// Self-checking testbench for the SHA-256 hash engine, with a built-in digest predictor.
`timescale 1ns / 1ps

module sha256_hash_engine_test;

    localparam int IDLE_LIMIT    = 5000;
    localparam int DRAIN_CYCLES  = 300;
    localparam int RANDOM_ITEMS  = 180;
    localparam int CALM_TAIL     = 40;
    localparam int PROBE_COUNT   = 18;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam int         LEN_FIELD = 56;
    localparam int         BLOCK_END = 63;

    // Digests of the empty message and of "abc"
    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

    localparam logic [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Message lengths around the padding and block boundaries
    localparam int EDGE_LENGTHS [6] = '{55, 56, 57, 63, 64, 65};

    typedef struct packed {
        logic [7:0]   data;
        logic         present;
        logic         finish;
        logic         typed;
        logic [255:0] digest;
    } probe_row_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_beat_t;

    // Directed items; a typed digest replaces the prediction where set
    localparam probe_row_t PROBE_ROWS [PROBE_COUNT] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // bare end right after reset
        '{8'ha5, 1'b0, 1'b0, 1'b0, 256'h0},        // idle item, byte ignored
        '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'hff, 1'b0, 1'b0, 1'b0, 256'h0},        // idle item inside a message
        '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // bare end right after a digest
        '{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h80, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h7f, 1'b1, 1'b1, 1'b0, 256'h0},
        '{8'h5a, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h00, 1'b0, 1'b1, 1'b0, 256'h0},        // bare end closes a message
        '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},        // one-byte message
        '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h63, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'hff, 1'b0, 1'b1, 1'b1, ABC_DIGEST}     // "abc" closed by a bare end
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] message_byte
    logic        s_axis_tuser = 1'b0;    // [0] byte_present
    logic        s_axis_tlast = 1'b0;    // end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [31:0] digest_word
    logic [2:0]  m_axis_tuser;           // [2:0] word_index
    logic        m_axis_tlast;           // last_word

    // Predictor state
    logic [31:0] digest_state [8];
    logic [7:0]  pending_block [64];
    logic [63:0] bytes_taken;
    logic [31:0] window [16];

    digest_beat_t pending_words [$];
    int           mismatch_count = 0;
    int           live_items = 0;
    int           idle_cycles = 0;
    int           stall_left = 0;
    bit           quiet = 1'b0;

    sha256_hash_engine uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Run the 64 rounds over pending_block into digest_state
    function automatic void crunch_block();
        logic [31:0] lane [8];
        logic [31:0] w, w2, w15, t1, t2;
        int          j;
        for (j = 0; j < 16; j++)
        begin
            window[j] = {pending_block[4*j], pending_block[4*j+1],
                         pending_block[4*j+2], pending_block[4*j+3]};
        end
        for (j = 0; j < 8; j++)
        begin
            lane[j] = digest_state[j];
        end
        for (j = 0; j < 64; j++)
        begin
            if (j < 16)
            begin
                w = window[j];
            end
            else
            begin
                w2  = window[(j - 2) & 15];
                w15 = window[(j - 15) & 15];
                w = (ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10)) + window[(j - 7) & 15]
                    + (ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3)) + window[j & 15];
                window[j & 15] = w;
            end
            t1 = lane[7] + (ror32(lane[4], 6) ^ ror32(lane[4], 11) ^ ror32(lane[4], 25))
                 + ((lane[4] & lane[5]) ^ (~lane[4] & lane[6])) + ROUND_CONST[j] + w;
            t2 = (ror32(lane[0], 2) ^ ror32(lane[0], 13) ^ ror32(lane[0], 22))
                 + ((lane[0] & lane[1]) ^ (lane[0] & lane[2]) ^ (lane[1] & lane[2]));
            lane[7] = lane[6];
            lane[6] = lane[5];
            lane[5] = lane[4];
            lane[4] = lane[3] + t1;
            lane[3] = lane[2];
            lane[2] = lane[1];
            lane[1] = lane[0];
            lane[0] = t1 + t2;
        end
        for (j = 0; j < 8; j++)
        begin
            digest_state[j] = digest_state[j] + lane[j];
        end
    endfunction

    // Absorb one item; on end of message pad, finish and return the digest
    function automatic logic absorb_item(input logic [7:0] b, input logic p, input logic e,
                                         output logic [255:0] digest);
        int          fill;
        int          k;
        logic [63:0] bit_len;
        digest = '0;
        if (p)
        begin
            fill = int'(bytes_taken[5:0]);
            pending_block[fill] = b;
            bytes_taken = bytes_taken + 64'd1;
            if (fill == BLOCK_END)
                crunch_block();
        end
        if (!e)
            return 1'b0;
        bit_len = bytes_taken << 3;
        fill = int'(bytes_taken[5:0]);
        pending_block[fill] = PAD_BYTE;
        fill++;
        // no room for the length: close this block and start another
        if (fill > LEN_FIELD)
        begin
            while (fill <= BLOCK_END)
            begin
                pending_block[fill] = 8'h00;
                fill++;
            end
            crunch_block();
            fill = 0;
        end
        while (fill < LEN_FIELD)
        begin
            pending_block[fill] = 8'h00;
            fill++;
        end
        for (k = 0; k < 8; k++)
        begin
            pending_block[LEN_FIELD + k] = bit_len[63 - 8*k -: 8];
        end
        crunch_block();
        for (k = 0; k < 8; k++)
        begin
            digest[255 - 32*k -: 32] = digest_state[k];
        end
        digest_state = START_HASH;
        bytes_taken = '0;
        return 1'b1;
    endfunction

    // Offer one item, wait for its transfer, then queue the digest words it causes
    task automatic push_item(input logic [7:0] b, input logic p, input logic e,
                             input logic typed, input logic [255:0] typed_digest);
        logic [255:0] digest;
        int           k;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= p;
        s_axis_tlast  <= e;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (p || e)
            live_items++;
        if (absorb_item(b, p, e, digest))
        begin
            if (typed)
                digest = typed_digest;
            for (k = 0; k < 8; k++)
            begin
                pending_words.push_back('{word: digest[255 - 32*k -: 32],
                                          idx: k[2:0], last: (k == 7)});
            end
        end
    endtask

    // Stall the result side in bursts and check each result transfer
    always @(posedge clk)
    begin
        digest_beat_t want;
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!quiet && rst_n && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 18);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end

        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word: got %h idx %0d last %0b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                mismatch_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (m_axis_tdata !== want.word || m_axis_tuser !== want.idx
                    || m_axis_tlast !== want.last)
                begin
                    $display({"%0t: digest word: expected %h idx %0d last %0b, ",
                              "got %h idx %0d last %0b"},
                             $time, want.word, want.idx, want.last,
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // Abort when neither side moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int msg_len;
        int n;
        bit bare_end;

        digest_state = START_HASH;
        bytes_taken = '0;
        for (n = 0; n < 64; n++)
        begin
            pending_block[n] = 8'h00;
        end
        for (n = 0; n < 16; n++)
        begin
            window[n] = '0;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items
        for (n = 0; n < PROBE_COUNT; n++)
        begin
            push_item(PROBE_ROWS[n].data, PROBE_ROWS[n].present, PROBE_ROWS[n].finish,
                      PROBE_ROWS[n].typed, PROBE_ROWS[n].digest);
        end

        // Random messages, some at the padding boundaries, with idle items mixed in
        live_items = 0;
        while (live_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) == 0)
                msg_len = EDGE_LENGTHS[$urandom_range(0, 5)];
            else
                msg_len = $urandom_range(0, 12);
            bare_end = (msg_len == 0) || ($urandom_range(0, 3) == 0);
            for (n = 0; n < msg_len; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
                push_item(8'($urandom_range(0, 255)), 1'b1, (n == msg_len - 1) && !bare_end,
                          1'b0, '0);
                quiet = (live_items >= RANDOM_ITEMS - CALM_TAIL);
            end
            if (bare_end)
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
            quiet = (live_items >= RANDOM_ITEMS - CALM_TAIL);
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then watch for stray words
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
